FILE: rtl/rse_pkg.sv
// ----------------------------------------------------------------------------
// Reed-Solomon systematic encoder package
// Shared constants, configuration register codes and small handshake types.
// ----------------------------------------------------------------------------
`default_nettype none

package rse_pkg;

  // Default field size and correction capability.
  localparam int unsigned SYMBOL_BITS_DEFAULT = 8;
  localparam int unsigned MAX_T_DEFAULT       = 16;

  // Widths fixed by the external interface.
  localparam int unsigned PORT_SYM_W   = 8;
  localparam int unsigned FIELD_POLY_W = 9;
  localparam int unsigned CORR_W       = 5;
  localparam int unsigned CFG_DATA_W   = 9;

  // Register values after reset.
  localparam logic [FIELD_POLY_W-1:0] FIELD_POLY_RESET = 9'd285;
  localparam logic [CORR_W-1:0]       CORR_RESET       = 5'd8;

  // Configuration register indices.
  typedef enum logic [0:0] {
    CFG_FIELD_POLY = 1'b0,
    CFG_CORR_SYM   = 1'b1
  } cfg_reg_e;

  // Flags that travel with an echoed symbol from the remainder stage.
  typedef struct packed {
    logic err;
    logic last;
  } res_flags_t;

  // Output sideband, first field in the highest bit.
  typedef struct packed {
    logic length_error;
    logic is_parity;
  } out_user_t;

endpackage

`default_nettype wire

FILE: rtl/rse_gf_mul.sv
// ----------------------------------------------------------------------------
// GF(2^m) multiplier
// Shift-and-add product of two symbols, reduced by the low bits of the field
// polynomial at every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module rse_gf_mul #(
  parameter int unsigned SYMBOL_BITS = rse_pkg::SYMBOL_BITS_DEFAULT
) (
  input  logic [SYMBOL_BITS-1:0] a_i,
  input  logic [SYMBOL_BITS-1:0] b_i,
  input  logic [SYMBOL_BITS-1:0] poly_i,
  output logic [SYMBOL_BITS-1:0] p_o
);

  logic [SYMBOL_BITS-1:0] acc;
  logic [SYMBOL_BITS-1:0] sh;

  // One partial product per bit of b; a is multiplied by x after each one.
  always_comb begin
    acc = '0;
    sh  = a_i;
    for (int k = 0; k < SYMBOL_BITS; k++) begin
      if (b_i[k]) begin
        acc = acc ^ sh;
      end
      sh = {sh[SYMBOL_BITS-2:0], 1'b0} ^ (sh[SYMBOL_BITS-1] ? poly_i : '0);
    end
    p_o = acc;
  end

endmodule

`default_nettype wire

FILE: rtl/rse_gen_build.sv
// ----------------------------------------------------------------------------
// Generator polynomial builder
// Holds the configuration registers and rebuilds the generator coefficients
// after reset and after every configuration write, one root per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rse_gen_build #(
  parameter int unsigned SYMBOL_BITS = rse_pkg::SYMBOL_BITS_DEFAULT,
  parameter int unsigned MAX_T       = rse_pkg::MAX_T_DEFAULT,
  localparam int unsigned NREGS      = 2 * MAX_T,
  localparam int unsigned NPW        = $clog2(2 * MAX_T + 1)
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  rse_pkg::cfg_reg_e                     cfg_index_i,
  input  logic [rse_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  output logic                                  busy_o,
  output logic [NREGS-1:0][SYMBOL_BITS-1:0]     gen_o,
  output logic [NPW-1:0]                        nparity_o,
  output logic [SYMBOL_BITS-1:0]                poly_o
);

  import rse_pkg::*;

  localparam int unsigned TW = (NPW > CORR_W + 1) ? NPW : CORR_W + 1;
  localparam int unsigned PW = (SYMBOL_BITS > FIELD_POLY_W) ? SYMBOL_BITS : FIELD_POLY_W;

  logic [FIELD_POLY_W-1:0]              field_poly_q;
  logic [CORR_W-1:0]                    corr_q;
  logic                                 start_q;
  logic                                 run_q;
  logic [NPW-1:0]                       step_q;
  logic [SYMBOL_BITS-1:0]               root_q;
  logic [SYMBOL_BITS-1:0]               root_x;
  logic [NREGS-1:0][SYMBOL_BITS-1:0]    g_q;
  logic [NREGS-1:0][SYMBOL_BITS-1:0]    g_d;
  logic [NREGS-1:0][SYMBOL_BITS-1:0]    gprod;
  logic [NPW-1:0]                       np_q;
  logic [SYMBOL_BITS-1:0]               poly_q;
  logic                                 cfg_wr;
  logic [TW-1:0]                        t_raw;
  logic [TW-1:0]                        t_eff;
  logic [NPW-1:0]                       np_start;
  logic [PW-1:0]                        poly_wide;

  // The register port never stalls.
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_poly_q <= FIELD_POLY_RESET;
      corr_q       <= CORR_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index_i)
        CFG_FIELD_POLY: field_poly_q <= cfg_data_i[FIELD_POLY_W-1:0];
        CFG_CORR_SYM:   corr_q       <= cfg_data_i[CORR_W-1:0];
      endcase
    end
  end

  // Clamp t into 1..MAX_T and form the parity count and field reduction bits.
  assign t_raw     = TW'(corr_q);
  assign t_eff     = (t_raw == '0) ? TW'(1) :
                     ((t_raw > TW'(MAX_T)) ? TW'(MAX_T) : t_raw);
  assign np_start  = NPW'({t_eff, 1'b0});
  assign poly_wide = PW'(field_poly_q);

  // Multiply every coefficient by the current root in parallel.
  for (genvar j = 0; j < NREGS; j++) begin : g_root_mul
    rse_gf_mul #(
      .SYMBOL_BITS (SYMBOL_BITS)
    ) u_mul (
      .a_i    (g_q[j]),
      .b_i    (root_q),
      .poly_i (poly_q),
      .p_o    (gprod[j])
    );
  end

  // g(x) <- g(x) * (x + root): each coefficient takes its lower neighbour.
  assign g_d    = gprod ^ {g_q[NREGS-2:0], SYMBOL_BITS'(0)};
  assign root_x = {root_q[SYMBOL_BITS-2:0], 1'b0} ^
                  (root_q[SYMBOL_BITS-1] ? poly_q : '0);

  // Build sequencer: a pending start restarts the build from g(x) = 1.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b1;
      run_q   <= 1'b0;
      step_q  <= '0;
    end else begin
      start_q <= cfg_wr;
      if (start_q) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        if (step_q == np_q - NPW'(1)) begin
          run_q <= 1'b0;
        end
        step_q <= step_q + NPW'(1);
      end
    end
  end

  // Coefficient, root and latched setting registers; g(x) starts as 1.
  always_ff @(posedge clk_i) begin
    if (start_q) begin
      np_q      <= np_start;
      poly_q    <= poly_wide[SYMBOL_BITS-1:0];
      root_q    <= SYMBOL_BITS'(2);
      g_q       <= (NREGS * SYMBOL_BITS)'(1);
    end else if (run_q) begin
      g_q    <= g_d;
      root_q <= root_x;
    end
  end

  assign busy_o    = start_q | run_q;
  assign gen_o     = g_q;
  assign nparity_o = np_q;
  assign poly_o    = poly_q;

  // The build never runs past the parity count it was started with.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q && !start_q |-> step_q < np_q)
    else $error("generator build ran past its root count");

endmodule

`default_nettype wire

FILE: rtl/rse_lfsr.sv
// ----------------------------------------------------------------------------
// Parity remainder stage
// Input register and the 2t-stage division register. Each symbol updates all
// taps at once and is handed on together with a snapshot of the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module rse_lfsr #(
  parameter int unsigned SYMBOL_BITS = rse_pkg::SYMBOL_BITS_DEFAULT,
  parameter int unsigned MAX_T       = rse_pkg::MAX_T_DEFAULT,
  localparam int unsigned NREGS      = 2 * MAX_T,
  localparam int unsigned NPW        = $clog2(2 * MAX_T + 1)
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        s_valid_i,
  output logic                                        s_ready_o,
  input  logic [rse_pkg::PORT_SYM_W-1:0]              s_sym_i,
  input  logic                                        s_last_i,
  input  logic                                        busy_i,
  input  logic [NREGS-1:0][SYMBOL_BITS-1:0]           gen_i,
  input  logic [NPW-1:0]                              nparity_i,
  input  logic [SYMBOL_BITS-1:0]                      poly_i,
  input  logic                                        res_ready_i,
  output logic                                        res_valid_o,
  output logic [rse_pkg::PORT_SYM_W-1:0]              res_sym_o,
  output rse_pkg::res_flags_t                         res_flags_o,
  output logic [NPW-1:0]                              res_np_o,
  output logic [NREGS-1:0][rse_pkg::PORT_SYM_W-1:0]   res_parity_o
);

  import rse_pkg::*;

  localparam int unsigned IW = $clog2(NREGS);
  localparam int unsigned XW = (SYMBOL_BITS > PORT_SYM_W) ? SYMBOL_BITS : PORT_SYM_W;
  localparam int unsigned CW = ((SYMBOL_BITS > NPW) ? SYMBOL_BITS : NPW) + 1;
  localparam logic [SYMBOL_BITS-1:0] SYM_MAX = '1;

  logic                                 in_valid_q;
  logic [SYMBOL_BITS-1:0]               in_sym_q;
  logic                                 in_last_q;
  logic [XW-1:0]                        sym_wide;
  logic [SYMBOL_BITS-1:0]               cnt_q;
  logic [SYMBOL_BITS-1:0]               cnt_inc;
  logic [NREGS-1:0][SYMBOL_BITS-1:0]    par_q;
  logic [NREGS-1:0][SYMBOL_BITS-1:0]    act_gen_q;
  logic [NPW-1:0]                       act_np_q;
  logic [SYMBOL_BITS-1:0]               act_poly_q;
  logic                                 msg_start;
  logic                                 fire;
  logic [NREGS-1:0][SYMBOL_BITS-1:0]    gen_sel;
  logic [NPW-1:0]                       np_sel;
  logic [SYMBOL_BITS-1:0]               poly_sel;
  logic [NREGS-1:0][SYMBOL_BITS-1:0]    p_old;
  logic [NREGS-1:0][SYMBOL_BITS-1:0]    p_shift;
  logic [NREGS-1:0][SYMBOL_BITS-1:0]    p_new;
  logic [NREGS-1:0][SYMBOL_BITS-1:0]    prod;
  logic [IW-1:0]                        top_idx;
  logic [SYMBOL_BITS-1:0]               fb;
  logic                                 err;
  logic [XW-1:0]                        echo_wide;
  logic [NREGS-1:0][XW-1:0]             par_wide;

  // Handshake: the first symbol of a message waits for a finished generator.
  assign msg_start   = (cnt_q == '0);
  assign res_valid_o = in_valid_q & ~(msg_start & busy_i);
  assign fire        = res_valid_o & res_ready_i;
  assign s_ready_o   = ~in_valid_q | fire;
  assign sym_wide    = XW'(s_sym_i);

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_ready_o) begin
      in_valid_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      in_sym_q  <= sym_wide[SYMBOL_BITS-1:0];
      in_last_q <= s_last_i;
    end
  end

  // A new message takes the freshly built generator and a cleared remainder.
  assign gen_sel  = msg_start ? gen_i     : act_gen_q;
  assign np_sel   = msg_start ? nparity_i : act_np_q;
  assign poly_sel = msg_start ? poly_i    : act_poly_q;
  assign p_old    = msg_start ? '0        : par_q;

  assign top_idx = IW'(np_sel - NPW'(1));
  assign fb      = in_sym_q ^ p_old[top_idx];

  // Feedback times every generator coefficient.
  for (genvar i = 0; i < NREGS; i++) begin : g_tap_mul
    rse_gf_mul #(
      .SYMBOL_BITS (SYMBOL_BITS)
    ) u_mul (
      .a_i    (fb),
      .b_i    (gen_sel[i]),
      .poly_i (poly_sel),
      .p_o    (prod[i])
    );
  end

  // Shift by one tap and add the products; taps above 2t stay clear.
  assign p_shift = {p_old[NREGS-2:0], SYMBOL_BITS'(0)};

  always_comb begin
    for (int i = 0; i < NREGS; i++) begin
      if (NPW'(i) < np_sel) begin
        p_new[i] = p_shift[i] ^ prod[i];
      end else begin
        p_new[i] = '0;
      end
    end
  end

  // Saturating message length and the length check against 2^m - 1 - 2t.
  assign cnt_inc = (cnt_q == SYM_MAX) ? cnt_q : cnt_q + SYMBOL_BITS'(1);
  assign err     = (CW'(cnt_inc) + CW'(np_sel)) > CW'(SYM_MAX);

  // Result towards the output stage.
  assign echo_wide        = XW'(in_sym_q);
  assign res_sym_o        = echo_wide[PORT_SYM_W-1:0];
  assign res_flags_o.err  = err;
  assign res_flags_o.last = in_last_q;
  assign res_np_o         = np_sel;

  for (genvar i = 0; i < NREGS; i++) begin : g_par_out
    assign par_wide[i]     = XW'(p_new[i]);
    assign res_parity_o[i] = par_wide[i][PORT_SYM_W-1:0];
  end

  // Symbol counter; the last symbol closes the message.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (fire) begin
      cnt_q <= in_last_q ? '0 : cnt_inc;
    end
  end

  // Remainder and the settings held for the running message.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      par_q <= p_new;
      if (msg_start) begin
        act_gen_q  <= gen_i;
        act_np_q   <= nparity_i;
        act_poly_q <= poly_i;
      end
    end
  end

  // After a closing symbol the next one starts a new message.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_last_q |=> cnt_q == '0)
    else $error("message counter not cleared after last symbol");

  // Inside a message the held parity count is non-zero and even.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != '0 |-> act_np_q != '0 && !act_np_q[0])
    else $error("held parity count is not a valid 2t");

endmodule

`default_nettype wire

FILE: rtl/rse_out.sv
// ----------------------------------------------------------------------------
// Output stage
// Result register towards the stream, plus the parity burst that follows
// the last symbol of a message, read from a snapshot of the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module rse_out #(
  parameter int unsigned MAX_T  = rse_pkg::MAX_T_DEFAULT,
  localparam int unsigned NREGS = 2 * MAX_T,
  localparam int unsigned NPW   = $clog2(2 * MAX_T + 1)
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        res_valid_i,
  output logic                                        res_ready_o,
  input  logic [rse_pkg::PORT_SYM_W-1:0]              res_sym_i,
  input  rse_pkg::res_flags_t                         res_flags_i,
  input  logic [NPW-1:0]                              res_np_i,
  input  logic [NREGS-1:0][rse_pkg::PORT_SYM_W-1:0]   res_parity_i,
  output logic                                        m_valid_o,
  input  logic                                        m_ready_i,
  output logic [rse_pkg::PORT_SYM_W-1:0]              m_data_o,
  output rse_pkg::out_user_t                          m_user_o,
  output logic                                        m_last_o
);

  import rse_pkg::*;

  localparam int unsigned IW = $clog2(NREGS);

  logic                                   ov_q;
  logic [PORT_SYM_W-1:0]                  od_q;
  out_user_t                              ou_q;
  logic                                   ol_q;
  logic                                   burst_q;
  logic [IW-1:0]                          k_q;
  logic [NREGS-1:0][PORT_SYM_W-1:0]       snap_q;
  logic                                   berr_q;
  logic                                   slot_free;
  logic                                   take;
  logic                                   emit;

  // The register frees up when empty or when its request is taken.
  assign slot_free   = ~ov_q | m_ready_i;
  assign res_ready_o = ~burst_q & slot_free;
  assign take        = res_valid_i & res_ready_o;
  assign emit        = burst_q & slot_free;

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (slot_free) begin
      ov_q <= take | emit;
    end
  end

  // Output payload: an echoed symbol or the next parity symbol.
  always_ff @(posedge clk_i) begin
    if (take) begin
      od_q <= res_sym_i;
      ou_q <= '{length_error: res_flags_i.err, is_parity: 1'b0};
      ol_q <= 1'b0;
    end else if (emit) begin
      od_q <= snap_q[k_q];
      ou_q <= '{length_error: berr_q, is_parity: 1'b1};
      ol_q <= (k_q == '0);
    end
  end

  // Parity burst control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_q <= 1'b0;
    end else if (take && res_flags_i.last) begin
      burst_q <= 1'b1;
    end else if (emit && k_q == '0) begin
      burst_q <= 1'b0;
    end
  end

  // Remainder snapshot, read from the highest tap down.
  always_ff @(posedge clk_i) begin
    if (take && res_flags_i.last) begin
      snap_q <= res_parity_i;
      k_q    <= IW'(res_np_i - NPW'(1));
      berr_q <= res_flags_i.err;
    end else if (emit) begin
      k_q <= k_q - IW'(1);
    end
  end

  assign m_valid_o = ov_q;
  assign m_data_o  = od_q;
  assign m_user_o  = ou_q;
  assign m_last_o  = ol_q;

  // While parity is pending the output register is never empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_q |-> ov_q)
    else $error("gap in parity burst");

  // Only a parity symbol can close a codeword.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && ol_q |-> ou_q.is_parity)
    else $error("codeword closed on a message symbol");

endmodule

`default_nettype wire

FILE: rtl/reed_solomon_systematic_encoder_unit.sv
// ----------------------------------------------------------------------------
// Reed-Solomon systematic encoder
// Echoes message symbols and appends 2t parity symbols computed with a
// parallel-update remainder register over GF(2^m), alpha = x.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Request carries
//   --------  ---------  ---------------------------------------------------
//   s_axis    in         message symbol (tdata), end of message (tlast)
//   m_axis    out        code symbol (tdata), parity/length flags (tuser),
//                        end of codeword (tlast)
//   cfg       in         register index and write data
//
// One message symbol per cycle unless stalled; each gives one echoed result
// through the input register and the result register. The last symbol of a
// message adds 2t parity results, during which input stalls. After reset and
// after each register write the generator is rebuilt, one root per cycle; only
// the first symbol of a message waits for it. Output stalls hold the result
// register and backpressure reaches the input through the input register.
//
`default_nettype none

module reed_solomon_systematic_encoder_unit #(
  parameter int unsigned SYMBOL_BITS = rse_pkg::SYMBOL_BITS_DEFAULT,
  parameter int unsigned MAX_T       = rse_pkg::MAX_T_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Message stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rse_pkg::PORT_SYM_W-1:0]    s_axis_tdata,   // [7:0] msg_symbol
  input  logic                              s_axis_tlast,   // last_symbol
  // Codeword stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rse_pkg::PORT_SYM_W-1:0]    m_axis_tdata,   // [7:0] code_symbol
  output rse_pkg::out_user_t                m_axis_tuser,   // [0] is_parity,
                                                            // [1] length_error
  output logic                              m_axis_tlast,   // last_of_codeword
  // Register writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  rse_pkg::cfg_reg_e                 cfg_index_i,
  input  logic [rse_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  import rse_pkg::*;

  localparam int unsigned NREGS = 2 * MAX_T;
  localparam int unsigned NPW   = $clog2(2 * MAX_T + 1);

  logic                                 gen_busy;
  logic [NREGS-1:0][SYMBOL_BITS-1:0]    gen_coeffs;
  logic [NPW-1:0]                       gen_np;
  logic [SYMBOL_BITS-1:0]               build_poly;
  logic                                 res_valid;
  logic                                 res_ready;
  logic [PORT_SYM_W-1:0]                res_sym;
  res_flags_t                           res_flags;
  logic [NPW-1:0]                       res_np;
  logic [NREGS-1:0][PORT_SYM_W-1:0]     res_parity;

  // Configuration registers and generator build.
  rse_gen_build #(
    .SYMBOL_BITS (SYMBOL_BITS),
    .MAX_T       (MAX_T)
  ) u_gen_build (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .busy_o      (gen_busy),
    .gen_o       (gen_coeffs),
    .nparity_o   (gen_np),
    .poly_o      (build_poly)
  );

  // Input register and remainder update.
  rse_lfsr #(
    .SYMBOL_BITS (SYMBOL_BITS),
    .MAX_T       (MAX_T)
  ) u_lfsr (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_sym_i      (s_axis_tdata),
    .s_last_i     (s_axis_tlast),
    .busy_i       (gen_busy),
    .gen_i        (gen_coeffs),
    .nparity_i    (gen_np),
    .poly_i       (build_poly),
    .res_ready_i  (res_ready),
    .res_valid_o  (res_valid),
    .res_sym_o    (res_sym),
    .res_flags_o  (res_flags),
    .res_np_o     (res_np),
    .res_parity_o (res_parity)
  );

  // Result register and parity burst.
  rse_out #(
    .MAX_T (MAX_T)
  ) u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_valid_i  (res_valid),
    .res_ready_o  (res_ready),
    .res_sym_i    (res_sym),
    .res_flags_i  (res_flags),
    .res_np_i     (res_np),
    .res_parity_i (res_parity),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_o     (m_axis_tdata),
    .m_user_o     (m_axis_tuser),
    .m_last_o     (m_axis_tlast)
  );

endmodule

`default_nettype wire

FILE: tb/rse_codeword_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Reed-Solomon encoder codeword checker
// Watches the register, message and codeword channels of the encoder. It keeps
// its own copy of the register settings, the generator polynomial and the
// parity remainder, predicts every codeword symbol that a message request
// causes, and compares each delivered symbol field by field with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module rse_codeword_checker #(
  parameter int unsigned SYMBOL_BITS = rse_pkg::SYMBOL_BITS_DEFAULT,
  parameter int unsigned MAX_T       = rse_pkg::MAX_T_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Message stream as seen at the encoder input
  input  logic                               s_axis_tvalid,
  input  logic                               s_axis_tready,
  input  logic [rse_pkg::PORT_SYM_W-1:0]     s_axis_tdata,   // [7:0] msg_symbol
  input  logic                               s_axis_tlast,   // last_symbol
  // Codeword stream as seen at the encoder output
  input  logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic [rse_pkg::PORT_SYM_W-1:0]     m_axis_tdata,   // [7:0] code_symbol
  input  rse_pkg::out_user_t                 m_axis_tuser,   // [0] is_parity,
                                                             // [1] length_error
  input  logic                               m_axis_tlast,   // last_of_codeword
  // Register writes
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  rse_pkg::cfg_reg_e                  cfg_index_i,
  input  logic [rse_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Status towards the testbench top
  output int unsigned                        pending_o,
  output int unsigned                        mismatches_o,
  output int unsigned                        codewords_o,
  output int unsigned                        overlong_o
);

  localparam int NPAR_MAX = 2 * MAX_T;
  localparam int SYM_MAX  = (1 << SYMBOL_BITS) - 1;

  typedef logic [SYMBOL_BITS-1:0] gf_sym_t;

  typedef struct packed {
    logic [rse_pkg::PORT_SYM_W-1:0] code_symbol;
    logic                           is_parity;
    logic                           last_of_codeword;
    logic                           length_error;
  } code_sym_t;

  // Predicted codeword symbols, oldest first.
  code_sym_t codeword_q[$];

  // Register copies as last written.
  logic [rse_pkg::FIELD_POLY_W-1:0] field_poly_r;
  logic [rse_pkg::CORR_W-1:0]       corr_sym_r;

  // Encoder state: settings latched per message, generator and remainder.
  int                     t_cur;
  logic [SYMBOL_BITS:0]   poly_cur;
  gf_sym_t                gen_coeff [NPAR_MAX];
  gf_sym_t                remainder [NPAR_MAX];
  int                     msg_len;

  // Shift-and-add multiplication modulo the latched field polynomial.
  function automatic gf_sym_t gf_mul(input gf_sym_t a_in, input gf_sym_t b_in);
    logic [SYMBOL_BITS:0] a;
    gf_sym_t              b;
    gf_sym_t              acc;
    a   = {1'b0, a_in};
    b   = b_in;
    acc = '0;
    for (int k = 0; k < SYMBOL_BITS; k++) begin
      if (b[0]) acc ^= a[SYMBOL_BITS-1:0];
      b = b >> 1;
      a = a << 1;
      if (a[SYMBOL_BITS]) a ^= poly_cur;
    end
    return acc;
  endfunction

  // Expands (x + alpha^1)...(x + alpha^2t) and keeps the low coefficients.
  function automatic void form_generator();
    gf_sym_t g [NPAR_MAX+1];
    gf_sym_t root;
    int      npar;
    npar = 2 * t_cur;
    root = gf_sym_t'(1);
    for (int j = 0; j <= NPAR_MAX; j++) g[j] = '0;
    g[0] = gf_sym_t'(1);
    for (int d = 0; d < npar; d++) begin
      root     = gf_mul(root, gf_sym_t'(2));
      g[d + 1] = g[d];
      for (int j = d; j > 0; j--) g[j] = g[j - 1] ^ gf_mul(g[j], root);
      g[0] = gf_mul(g[0], root);
    end
    for (int j = 0; j < NPAR_MAX; j++) gen_coeff[j] = (j < npar) ? g[j] : '0;
  endfunction

  // Predicts the results of one accepted message symbol.
  function automatic void encode_symbol(input gf_sym_t sym, input logic last);
    gf_sym_t   fb;
    int        npar;
    logic      overlong;
    code_sym_t res;
    // A new message latches the settings and rebuilds the generator.
    if (msg_len == 0) begin
      if (corr_sym_r == '0)          t_cur = 1;
      else if (corr_sym_r > MAX_T)   t_cur = MAX_T;
      else                           t_cur = int'(corr_sym_r);
      poly_cur = {1'b1, field_poly_r[SYMBOL_BITS-1:0]};
      for (int i = 0; i < NPAR_MAX; i++) remainder[i] = '0;
      form_generator();
    end
    npar = 2 * t_cur;

    // One division step of the remainder register.
    fb = sym ^ remainder[npar - 1];
    for (int i = npar - 1; i > 0; i--)
      remainder[i] = remainder[i - 1] ^ gf_mul(fb, gen_coeff[i]);
    remainder[0] = gf_mul(fb, gen_coeff[0]);

    if (msg_len < SYM_MAX) msg_len++;
    overlong = (msg_len > SYM_MAX - npar);
    if (overlong) overlong_o++;

    res.code_symbol      = rse_pkg::PORT_SYM_W'(sym);
    res.is_parity        = 1'b0;
    res.last_of_codeword = 1'b0;
    res.length_error     = overlong;
    codeword_q.push_back(res);

    // The last symbol releases the parity, highest degree first.
    if (last) begin
      for (int i = npar; i > 0; i--) begin
        res.code_symbol      = rse_pkg::PORT_SYM_W'(remainder[i - 1]);
        res.is_parity        = 1'b1;
        res.last_of_codeword = (i == 1);
        res.length_error     = overlong;
        codeword_q.push_back(res);
      end
      for (int i = 0; i < NPAR_MAX; i++) remainder[i] = '0;
      msg_len = 0;
      codewords_o++;
    end
  endfunction

  function automatic void compare_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatches_o++;
    end
  endfunction

  // Output is checked before the same edge's input is predicted, since a
  // symbol cannot leave the encoder in the cycle it is accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codeword_q.delete();
      field_poly_r = rse_pkg::FIELD_POLY_RESET;
      corr_sym_r   = rse_pkg::CORR_RESET;
      msg_len      = 0;
      t_cur        = 1;
      poly_cur     = '0;
      for (int i = 0; i < NPAR_MAX; i++) remainder[i] = '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (codeword_q.size() == 0) begin
          $error("unexpected codeword symbol %0h", m_axis_tdata);
          mismatches_o++;
        end else begin
          compare_field("code_symbol", codeword_q[0].code_symbol, m_axis_tdata);
          compare_field("is_parity", 8'(codeword_q[0].is_parity),
                        8'(m_axis_tuser.is_parity));
          compare_field("last_of_codeword", 8'(codeword_q[0].last_of_codeword),
                        8'(m_axis_tlast));
          compare_field("length_error", 8'(codeword_q[0].length_error),
                        8'(m_axis_tuser.length_error));
          void'(codeword_q.pop_front());
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        encode_symbol(s_axis_tdata[SYMBOL_BITS-1:0], s_axis_tlast);
      // A register write only takes effect from the next message on.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          rse_pkg::CFG_FIELD_POLY: begin
            field_poly_r = cfg_data_i[rse_pkg::FIELD_POLY_W-1:0];
          end
          rse_pkg::CFG_CORR_SYM: begin
            corr_sym_r = cfg_data_i[rse_pkg::CORR_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
    pending_o = codeword_q.size();
  end

endmodule

FILE: tb/tb_reed_solomon_systematic_encoder_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Reed-Solomon systematic encoder testbench
// Drives message requests and register writes into the encoder with random
// gaps and output stalls. A short directed run covers extreme symbols, odd
// field polynomials and out-of-range t; random phases follow with random
// settings and short messages. All checking is done by the checker.
// ----------------------------------------------------------------------------
module tb_reed_solomon_systematic_encoder_unit;

  logic                               clk_i         = 1'b0;
  logic                               rst_ni        = 1'b0;
  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic [rse_pkg::PORT_SYM_W-1:0]     s_axis_tdata  = '0;
  logic                               s_axis_tlast  = 1'b0;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  logic [rse_pkg::PORT_SYM_W-1:0]     m_axis_tdata;
  rse_pkg::out_user_t                 m_axis_tuser;
  logic                               m_axis_tlast;
  logic                               cfg_valid_i   = 1'b0;
  logic                               cfg_ready_o;
  rse_pkg::cfg_reg_e                  cfg_index_i   = rse_pkg::CFG_FIELD_POLY;
  logic [rse_pkg::CFG_DATA_W-1:0]     cfg_data_i    = '0;

  int unsigned pending;
  int unsigned mismatches;
  int unsigned codewords;
  int unsigned overlong;

  int unsigned symbols_sent  = 0;
  int unsigned settings_used = 1;
  int unsigned hold_cnt      = 0;
  logic        steady        = 1'b0;

  always #1 clk_i = ~clk_i;

  reed_solomon_systematic_encoder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  rse_codeword_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pending_o     (pending),
    .mismatches_o  (mismatches),
    .codewords_o   (codewords),
    .overlong_o    (overlong)
  );

  // Idle stretch length: mostly short, now and then a long one.
  function automatic int unsigned gap_len();
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random field polynomial: mostly primitive ones, sometimes any 9-bit value.
  function automatic logic [8:0] pick_poly();
    case ($urandom_range(0, 5))
      0:       return 9'd285;
      1:       return 9'd299;
      2:       return 9'd301;
      3:       return 9'd361;
      4:       return 9'd487;
      default: return 9'($urandom_range(0, 511));
    endcase
  endfunction

  // Random t: mostly in range, sometimes anything the register holds.
  function automatic logic [8:0] pick_t();
    if ($urandom_range(0, 4) == 0) return 9'($urandom_range(0, 31));
    return 9'($urandom_range(1, 16));
  endfunction

  // Receiver stalls.
  always @(posedge clk_i) begin
    if (hold_cnt != 0) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= hold_cnt - 1;
    end else if (!steady && $urandom_range(0, 4) == 0) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= gap_len() - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Sends one message request; valid stays high afterwards so that a
  // following request can go out back to back.
  task automatic send_symbol(input logic [7:0] sym, input logic last);
    int unsigned gap;
    gap = (steady || $urandom_range(0, 3) != 0) ? 0 : gap_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sym;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    symbols_sent++;
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      send_symbol(8'($urandom_range(0, 255)), i == len - 1);
  endtask

  // Lowers valid and waits until every predicted symbol has been delivered.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input rse_pkg::cfg_reg_e idx, input logic [8:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic configure(input logic set_poly, input logic [8:0] poly,
                           input logic set_t, input logic [8:0] t_val);
    if (set_poly) write_reg(rse_pkg::CFG_FIELD_POLY, poly);
    if (set_t)    write_reg(rse_pkg::CFG_CORR_SYM, t_val);
    cfg_valid_i <= 1'b0;
    steady      <= ($urandom_range(0, 3) == 0);
    settings_used++;
  endtask

  initial begin
    int unsigned n_msgs;
    int unsigned choice;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: extreme symbols and a short mixed message.
    send_symbol(8'hFF, 1'b1);
    send_symbol(8'h00, 1'b1);
    send_symbol(8'h01, 1'b0);
    send_symbol(8'h80, 1'b0);
    send_symbol(8'h55, 1'b0);
    send_symbol(8'hAA, 1'b1);
    wait_idle();

    // x^8 bit left out of the polynomial, and t of zero.
    configure(1'b1, 9'h01D, 1'b1, 9'd0);
    send_symbol(8'hFF, 1'b0);
    send_symbol(8'h00, 1'b1);
    wait_idle();

    // All polynomial bits set, and t above the maximum.
    configure(1'b1, 9'd511, 1'b1, 9'd31);
    send_symbol(8'h12, 1'b0);
    send_symbol(8'hFF, 1'b0);
    send_symbol(8'h00, 1'b1);
    wait_idle();

    // Non-primitive polynomials at the largest and smallest t.
    configure(1'b1, 9'd257, 1'b1, 9'd16);
    send_symbol(8'hFF, 1'b0);
    send_symbol(8'h01, 1'b1);
    wait_idle();
    configure(1'b1, 9'd0, 1'b1, 9'd1);
    send_symbol(8'h80, 1'b1);
    wait_idle();

    // Random phases with random settings and short messages.
    for (int p = 0; p < 12; p++) begin
      choice = $urandom_range(0, 2);
      configure(choice != 1, pick_poly(), choice != 0, pick_t());
      n_msgs = $urandom_range(1, 4);
      repeat (n_msgs) send_message($urandom_range(1, 8));
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    $display("Encoded %0d message symbols into %0d codewords across %0d register settings.",
             symbols_sent, codewords, settings_used);
    $display("%0d message symbols were predicted with the length error raised.", overlong);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
